FILE: hw/rtl/wildcard_pattern_matcher_top_assert.svh
// Assertion macros for the wildcard pattern matcher checker.
// Included by the checker file; depends on nothing else.
`ifndef WILDCARD_PATTERN_MATCHER_TOP_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WPM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpm: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define WPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpm: next-cycle check failed");

`endif

FILE: hw/rtl/wpm_pkg.sv
// Shared constants and types of the wildcard pattern matcher.
// No dependencies; used by the controller, the cells, the top level and the checker.
`timescale 1ns / 1ps

package wpm_pkg;

  // Command codes carried by an input transaction
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_SUBJECT = 1'b1;

  // Wildcard bytes in a pattern
  localparam logic [7:0] STAR_CODE     = 8'd42;
  localparam logic [7:0] QUESTION_CODE = 8'd63;

  // Control broadcast from the controller to every position cell
  typedef struct packed {
    logic step;   // a subject byte is accepted: advance the active set
    logic fresh;  // the subject byte starts a new subject: use the seed set
    logic clear;  // a new pattern starts: drop all stored bytes
    logic load;   // store the pattern byte at the write index
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/wpm_if.sv
// Valid/ready channel interfaces of the wildcard pattern matcher.
// Depends on nothing; instantiated around the top level.
`timescale 1ns / 1ps

interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output command, output char_code, output last,
                  input ready);
  modport sink   (input valid, input command, input char_code, input last,
                  output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflowed;

  modport source (output valid, output matched, output pattern_overflowed,
                  input ready);
  modport sink   (input valid, input matched, input pattern_overflowed,
                  output ready);
endinterface

FILE: hw/rtl/wildcard_pattern_matcher_top.sv
// Top level of the wildcard pattern matcher: controller, chain of position cells,
// result register. Depends on wpm_pkg, wpm_if, wpm_ctrl and wpm_cell.
//
//   channel | modport | moves per transaction
//   --------+---------+---------------------------------------------
//   in_i    | sink    | command, char_code, last
//   out_o   | source  | matched, pattern_overflowed (subject end only)
//
// A transaction moves when in_i.valid and in_i.ready are high; the active set of all
// pattern positions advances in one step through the row of MAX_PATTERN cells.
// The result of a subject's last byte is in the output register the cycle after.
// in_i.ready drops only while a result waits in the output register and out_o
// is not taking it. Reset is asynchronous and active low; no clearing pass.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_top #(
  parameter int MAX_PATTERN = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpm_in_if.sink    in_i,
  wpm_out_if.source out_o
);

  localparam int LENW = $clog2(MAX_PATTERN + 1);

  wpm_pkg::cell_ctrl_t  cell_ctrl;
  logic [LENW-1:0]      wr_idx;
  logic                 overflow;
  logic                 in_acc;
  logic                 pat_acc;
  logic                 sub_acc;
  logic [MAX_PATTERN-1:0] move;
  logic [MAX_PATTERN-1:0] clos;
  logic [MAX_PATTERN-1:0] vld;
  logic [MAX_PATTERN-1:0] star_vld;
  logic [MAX_PATTERN-1:0] hit;
  logic                 end_hit;
  logic                 matched;
  logic                 out_valid_q, out_valid_d;
  logic                 matched_q;
  logic                 ovf_q;
  logic                 res_load;

  // Accept while the output register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign pat_acc    = in_acc && (in_i.command == wpm_pkg::CMD_PATTERN);
  assign sub_acc    = in_acc && (in_i.command == wpm_pkg::CMD_SUBJECT);

  wpm_ctrl #(
    .MAX_PATTERN (MAX_PATTERN),
    .LENW        (LENW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pat_acc_i   (pat_acc),
    .sub_acc_i   (sub_acc),
    .char_code_i (in_i.char_code),
    .last_i      (in_i.last),
    .ctrl_o      (cell_ctrl),
    .wr_idx_o    (wr_idx),
    .overflow_o  (overflow)
  );

  // Row of position cells, each handing move and closure bits to its right
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic mv_in;
    logic cl_in;
    logic lv_in;
    if (j == 0) begin : g_first
      assign mv_in = 1'b0;
      assign cl_in = 1'b0;
      assign lv_in = 1'b1;
    end else begin : g_rest
      assign mv_in = move[j-1];
      assign cl_in = clos[j-1];
      assign lv_in = vld[j-1];
    end
    wpm_cell #(
      .IDX  (j),
      .LENW (LENW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .wr_idx_i     (wr_idx),
      .char_code_i  (in_i.char_code),
      .start_star_i (star_vld[0]),
      .move_i       (mv_in),
      .clos_i       (cl_in),
      .left_vld_i   (lv_in),
      .move_o       (move[j]),
      .clos_o       (clos[j]),
      .vld_o        (vld[j]),
      .star_vld_o   (star_vld[j]),
      .hit_o        (hit[j])
    );
  end

  // Position past a full row: no byte, no outgoing moves
  assign end_hit = (move[MAX_PATTERN-1] || clos[MAX_PATTERN-1]) && vld[MAX_PATTERN-1];
  assign matched = (|hit) || end_hit;

  // Hold the result until taken; refill in the same cycle it drains
  assign res_load = sub_acc && in_i.last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      matched_q <= matched;
      ovf_q     <= overflow;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.matched            = matched_q;
  assign out_o.pattern_overflowed = ovf_q;

endmodule

FILE: hw/rtl/wpm_cell.sv
// One pattern position cell: stored byte, valid bit and active bit.
// Depends on wpm_pkg; chained by the top level, one cell per pattern position.
`timescale 1ns / 1ps

module wpm_cell #(
  parameter int IDX  = 0,
  parameter int LENW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpm_pkg::cell_ctrl_t ctrl_i,
  input  logic [LENW-1:0]     wr_idx_i,
  input  logic [7:0]          char_code_i,
  input  logic                start_star_i,
  input  logic                move_i,
  input  logic                clos_i,
  input  logic                left_vld_i,
  output logic                move_o,
  output logic                clos_o,
  output logic                vld_o,
  output logic                star_vld_o,
  output logic                hit_o
);

  logic       valid_q;
  logic       act_q, act_d;
  logic [7:0] byte_q;
  logic       seed;
  logic       act_eff;
  logic       is_star;
  logic       char_hit;
  logic       pre;

  // Store the pattern byte; a new pattern drops the old one first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= 1'b0;
      end
      if (ctrl_i.load && (wr_idx_i == LENW'(IDX))) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && (wr_idx_i == LENW'(IDX))) begin
      byte_q <= char_code_i;
    end
  end

  // Seed set of a new subject: position zero, plus position one behind a star
  assign seed    = (IDX == 0) ? 1'b1 : ((IDX == 1) ? start_star_i : 1'b0);
  assign act_eff = ctrl_i.fresh ? seed : act_q;

  assign is_star  = (byte_q == wpm_pkg::STAR_CODE);
  assign char_hit = (byte_q == wpm_pkg::QUESTION_CODE) || (byte_q == char_code_i);

  // Hand activity to the right neighbor on a consumed byte; stars keep their own
  assign move_o = act_eff && valid_q && !is_star && char_hit;
  assign pre    = (act_eff && valid_q && is_star) || move_i;
  // A star matches the empty run: close over it into the neighbor
  assign clos_o = pre && valid_q && is_star;
  assign act_d  = pre || clos_i;

  assign vld_o      = valid_q;
  assign star_vld_o = valid_q && is_star;
  // First position without a byte is the end of the pattern
  assign hit_o      = act_d && left_vld_i && !valid_q;

  // Advance the active bit on every subject byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctrl_i.step) begin
      act_q <= act_d;
    end
  end

endmodule

FILE: hw/rtl/wpm_ctrl.sv
// Load and subject controller: write pointer, overflow flag, load and subject state.
// Depends on wpm_pkg; drives the control broadcast to the position cells.
`timescale 1ns / 1ps

module wpm_ctrl #(
  parameter int MAX_PATTERN = 128,
  parameter int LENW        = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pat_acc_i,
  input  logic                sub_acc_i,
  input  logic [7:0]          char_code_i,
  input  logic                last_i,
  output wpm_pkg::cell_ctrl_t ctrl_o,
  output logic [LENW-1:0]     wr_idx_o,
  output logic                overflow_o
);

  logic            loading_q, loading_d;
  logic            fresh_q, fresh_d;
  logic            last_star_q, last_star_d;
  logic            overflow_q, overflow_d;
  logic [LENW-1:0] raw_cnt_q, raw_cnt_d;
  logic [LENW-1:0] wr_ptr_q, wr_ptr_d;
  logic            new_pat;
  logic [LENW-1:0] raw_base;
  logic [LENW-1:0] ptr_base;
  logic            ls_base;
  logic            in_star;
  logic            store;

  assign new_pat  = pat_acc_i && !loading_q;
  assign raw_base = new_pat ? '0 : raw_cnt_q;
  assign ptr_base = new_pat ? '0 : wr_ptr_q;
  assign ls_base  = new_pat ? 1'b0 : last_star_q;
  assign in_star  = (char_code_i == wpm_pkg::STAR_CODE);

  // Store a byte within capacity, folding a run of stars into one star
  assign store = pat_acc_i && (raw_base < LENW'(MAX_PATTERN)) && !(in_star && ls_base);

  always_comb begin
    loading_d   = loading_q;
    fresh_d     = fresh_q;
    last_star_d = last_star_q;
    overflow_d  = overflow_q;
    raw_cnt_d   = raw_cnt_q;
    wr_ptr_d    = wr_ptr_q;
    if (pat_acc_i) begin
      loading_d   = !last_i;
      fresh_d     = 1'b1;
      last_star_d = ls_base;
      raw_cnt_d   = raw_base;
      wr_ptr_d    = ptr_base;
      overflow_d  = new_pat ? 1'b0 : overflow_q;
      if (raw_base < LENW'(MAX_PATTERN)) begin
        raw_cnt_d = raw_base + LENW'(1);
        if (store) begin
          wr_ptr_d    = ptr_base + LENW'(1);
          last_star_d = in_star;
        end
      end else begin
        overflow_d = 1'b1;
      end
    end else if (sub_acc_i) begin
      loading_d = 1'b0;
      fresh_d   = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q   <= 1'b0;
      fresh_q     <= 1'b1;
      last_star_q <= 1'b0;
      overflow_q  <= 1'b0;
      raw_cnt_q   <= '0;
      wr_ptr_q    <= '0;
    end else begin
      loading_q   <= loading_d;
      fresh_q     <= fresh_d;
      last_star_q <= last_star_d;
      overflow_q  <= overflow_d;
      raw_cnt_q   <= raw_cnt_d;
      wr_ptr_q    <= wr_ptr_d;
    end
  end

  // Broadcast to the cells
  assign ctrl_o.step  = sub_acc_i;
  assign ctrl_o.fresh = fresh_q;
  assign ctrl_o.clear = new_pat;
  assign ctrl_o.load  = store;
  assign wr_idx_o     = ptr_base;
  assign overflow_o   = overflow_q;

endmodule

FILE: hw/rtl/wpm_checker.sv
// Port-level checker of the wildcard pattern matcher, bound to the top level.
// Depends on wpm_pkg and the macros in wildcard_pattern_matcher_top_assert.svh.
`timescale 1ns / 1ps
`include "wildcard_pattern_matcher_top_assert.svh"

module wpm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched,
  input logic out_overflowed
);

  logic sub_last_acc;

  assign sub_last_acc = in_valid && in_ready && (in_command == wpm_pkg::CMD_SUBJECT) && in_last;

  // Input is never blocked while the output register is empty
  `WPM_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !out_valid, in_ready)

  // A finished subject yields a result in the next cycle
  `WPM_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, sub_last_acc, out_valid)

  // A result appears only after a finished subject
  `WPM_ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, $rose(out_valid), $past(sub_last_acc))

  // A stalled result stays
  `WPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)

  // A stalled result keeps its payload
  `WPM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid && !out_ready, $stable(out_matched) && $stable(out_overflowed))

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .in_command     (in_i.command),
  .in_last        (in_i.last),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_matched    (out_o.matched),
  .out_overflowed (out_o.pattern_overflowed)
);
